/* hdl/lssa_pkg.sv */
// Shared types, constants and the arctangent table of the lidar scan block.
package lssa_pkg;

  // Range, angle, sector and position widths
  localparam int unsigned RangeW = 16;
  localparam int unsigned AngleW = 16;
  localparam int unsigned SectW  = 9;
  localparam int unsigned PosW   = 17;

  // Scan accumulation
  localparam int unsigned SumW       = 26;
  localparam int unsigned CountW     = 10;
  localparam int unsigned DivW       = 27;
  localparam logic [CountW-1:0] CountLimit = 10'd1023;

  // CORDIC datapath: 14 fractional bits, Q0.32 gain
  localparam int unsigned CordW     = 34;
  localparam int unsigned AtanW     = 30;
  localparam int unsigned MaxSteps  = 24;
  localparam logic [31:0] CordicGain = 32'd2608131496;
  localparam logic [RangeW-1:0] RangeMax = 16'hFFFF;

  // Register reset values
  localparam logic [AngleW-1:0] StartAngleRst  = 16'd0;
  localparam logic [AngleW-1:0] AngleStepRst   = 16'd182;
  localparam logic [SectW-1:0]  SectorEndRst   = 9'd44;
  localparam logic [SectW-1:0]  SectorStartRst = 9'd314;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_ANGLE  = 2'd0,
    REG_ANGLE_STEP   = 2'd1,
    REG_SECTOR_END   = 2'd2,
    REG_SECTOR_START = 2'd3
  } cfg_reg_e;

  // Status of the rotation unit
  typedef struct packed {
    logic                   busy;
    logic signed [PosW-1:0] x_pos;
    logic signed [PosW-1:0] y_pos;
  } cordic_res_t;

  // Status of the divider
  typedef struct packed {
    logic              busy;
    logic [RangeW-1:0] quotient;
  } div_res_t;

  // Arctangent of 2^-i in units of 2^32 per turn
  function automatic logic [AtanW-1:0] atan_turn(input logic [4:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/lssa_cordic.sv */
// Iterative CORDIC rotation: one shared add/shift step per cycle turns a range into x,y.
module lssa_cordic import lssa_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RangeW-1:0] range_i,
  input  logic [AngleW-1:0] angle_i,
  output cordic_res_t       res_o
);

  localparam int unsigned NStep = (CORDIC_STEPS < MaxSteps) ? CORDIC_STEPS : MaxSteps;
  localparam int unsigned IterW = $clog2(NStep);

  logic [47:0]             prod_q;
  logic signed [AngleW-1:0] fold_q;
  logic                    flip_q;
  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [IterW-1:0]        iter_q;
  logic                    busy_q, load_q;

  logic signed [16:0]      ang_s, ang_f;
  logic                    flip_d;
  logic [47:0]             prod_rnd;
  logic signed [CordW-1:0] x0, xs, ys, at;

  // Fold the angle into the right half plane
  always_comb begin
    ang_s  = 17'(signed'(angle_i));
    ang_f  = ang_s;
    flip_d = 1'b0;
    if (ang_s > 17'sd16384) begin
      ang_f  = ang_s - 17'sd32768;
      flip_d = 1'b1;
    end else if (ang_s < -17'sd16384) begin
      ang_f  = ang_s + 17'sd32768;
      flip_d = 1'b1;
    end
  end

  // Scale the range by the CORDIC gain, rounding half up
  assign prod_rnd = prod_q + 48'd131072;
  assign x0       = signed'({4'b0000, prod_rnd[47:18]});

  // Shared rotation step
  assign xs = x_q >>> iter_q;
  assign ys = y_q >>> iter_q;
  assign at = signed'({4'b0000, atan_turn(5'(iter_q))});

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (load_q) begin
      x_d = flip_q ? -x0 : x0;
      y_d = '0;
      z_d = signed'({{2{fold_q[AngleW-1]}}, fold_q, 16'h0000});
    end else if (busy_q) begin
      if (!z_q[CordW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
    end
  end

  // Sequence: capture, load, then one rotation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      load_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      load_q <= 1'b1;
      iter_q <= '0;
    end else if (load_q) begin
      load_q <= 1'b0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == IterW'(NStep - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 48'(range_i) * 48'(CordicGain);
      fold_q <= ang_f[AngleW-1:0];
      flip_q <= flip_d;
    end
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // Round to signed Q16.0 in the 17-bit position width and limit to the field range
  function automatic logic signed [PosW-1:0] to_pos(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65535) begin
      r = 34'sd65535;
    end else if (r < -34'sd65535) begin
      r = -34'sd65535;
    end
    return r[PosW-1:0];
  endfunction

  assign res_o.busy  = busy_q;
  assign res_o.x_pos = to_pos(x_q);
  assign res_o.y_pos = to_pos(y_q);

endmodule

/* hdl/lssa_div.sv */
// Restoring divider, one quotient bit per cycle, for the scan mean.
module lssa_div import lssa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivW-1:0]   dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output div_res_t          res_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [CountW-1:0] rem_q, rem_d;
  logic [DivW-1:0]   quo_q, quo_d;
  logic [CountW-1:0] dsr_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic [CountW:0]   trial;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    rem_d = trial[CountW-1:0];
    quo_d = {quo_q[DivW-2:0], 1'b0};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d    = CountW'(trial - {1'b0, dsr_q});
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign res_o.busy     = busy_q;
  assign res_o.quotient = quo_q[RangeW-1:0];

endmodule

/* hdl/lidar_scan_points_sector_average.sv */
// Top level: lidar range samples to x,y points with a front-sector mean per scan.
//
// Input beats carry one range sample each, in scan order; every accepted beat
// gives exactly one output beat with the point and, on the last sample, the
// rounded mean of the counted front-sector ranges. Both channels use valid and
// stall; a beat moves when valid is high and stall is low.
// The beam angle is start_angle + index * angle_step; the point comes from an
// iterative CORDIC that does one rotation step per cycle, and a sample is not
// finished until all its rotation steps are done. The last sample of a scan
// with counted ranges also runs the bit-serial divider in parallel and waits
// for the quotient too. The block stalls its input while one sample is in
// work; a finished result sits in the output register, so the next sample is
// taken while the receiver still stalls, and work on it pauses at its end
// until the previous beat has gone.
// Reset clears the scan index, sum and count, loads the register defaults and
// empties the output register. Configuration writes take effect at once and
// belong between samples.
module lidar_scan_points_sector_average import lssa_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = 512,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [AngleW-1:0]      cfg_data_i,
  // sample input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [RangeW-1:0]      range_sample_i,
  input  logic                   range_invalid_i,
  input  logic                   range_infinite_i,
  input  logic                   last_sample_i,
  // point output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PosW-1:0] x_pos_o,
  output logic signed [PosW-1:0] y_pos_o,
  output logic                   scan_done_o,
  output logic [RangeW-1:0]      mean_range_o,
  output logic                   mean_valid_o
);

  localparam int unsigned IdxW = $clog2(MAX_SAMPLES);
  localparam int unsigned CmpW = (IdxW > SectW) ? IdxW : SectW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [AngleW-1:0] start_angle_q, angle_step_q;
  logic [SectW-1:0]  sector_end_q, sector_start_q;
  logic [IdxW-1:0]   idx_q;
  logic [SumW-1:0]   sum_q, sum_nx;
  logic [CountW-1:0] cnt_q, cnt_nx;
  logic              invalid_q, last_q, mvalid_q;
  logic              out_valid_q;

  logic              in_acc, out_acc, finish;
  logic              in_sector, count_en, div_start;
  logic [RangeW-1:0] range_eff;
  logic [AngleW-1:0] angle;
  logic [DivW-1:0]   dividend;
  cordic_res_t       cordic_res;
  div_res_t          div_res;

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign finish     = (state_q == ST_WORK) && !cordic_res.busy && !div_res.busy
                      && (!out_valid_q || !out_stall_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q  <= StartAngleRst;
      angle_step_q   <= AngleStepRst;
      sector_end_q   <= SectorEndRst;
      sector_start_q <= SectorStartRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START_ANGLE:  start_angle_q  <= cfg_data_i;
        REG_ANGLE_STEP:   angle_step_q   <= cfg_data_i;
        REG_SECTOR_END:   sector_end_q   <= cfg_data_i[SectW-1:0];
        REG_SECTOR_START: sector_start_q <= cfg_data_i[SectW-1:0];
        default: ;
      endcase
    end
  end

  // Beam angle, sector test and counting of the incoming sample
  assign angle     = start_angle_q + AngleW'(idx_q * angle_step_q);
  assign in_sector = (CmpW'(idx_q) <= CmpW'(sector_end_q))
                     || (CmpW'(idx_q) >= CmpW'(sector_start_q));
  assign range_eff = range_infinite_i ? RangeMax : range_sample_i;
  assign count_en  = in_sector && !range_invalid_i && !range_infinite_i
                     && (cnt_q != CountLimit);
  assign sum_nx    = sum_q + (count_en ? SumW'(range_sample_i) : '0);
  assign cnt_nx    = cnt_q + (count_en ? CountW'(1) : '0);
  assign dividend  = DivW'(sum_nx) + DivW'(cnt_nx >> 1);
  assign div_start = in_acc && last_sample_i && (cnt_nx != '0);

  // Scan state: advance the index, accumulate, clear on the last sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (in_acc) begin
      if (last_sample_i) begin
        idx_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_nx;
        cnt_q <= cnt_nx;
        if (idx_q != IdxW'(MAX_SAMPLES - 1)) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Hold the sample flags for the output beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      invalid_q <= range_invalid_i;
      last_q    <= last_sample_i;
      mvalid_q  <= last_sample_i && (cnt_nx != '0);
    end
  end

  lssa_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .range_i(range_eff),
    .angle_i(angle),
    .res_o  (cordic_res)
  );

  lssa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (cnt_nx),
    .res_o     (div_res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_WORK;
      ST_WORK: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      x_pos_o      <= invalid_q ? '0 : cordic_res.x_pos;
      y_pos_o      <= invalid_q ? '0 : cordic_res.y_pos;
      scan_done_o  <= last_q;
      mean_range_o <= mvalid_q ? div_res.quotient : '0;
      mean_valid_o <= mvalid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_cordic_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> cordic_res.busy)
    else $error("rotation unit not started by accepted sample");

  a_mean_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !scan_done_o) |-> (!mean_valid_o && mean_range_o == '0))
    else $error("mean given outside the last sample");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!div_res.busy && !cordic_res.busy))
    else $error("arithmetic unit busy while idle");

endmodule
